FILE: rtl/afc_pkg.sv
package afc_pkg;

    // input item kinds
    localparam logic [1:0] ACT_LOAD_PLANE  = 2'd0;
    localparam logic [1:0] ACT_LOAD_CORNER = 2'd1;
    localparam logic [1:0] ACT_TEST_BOX    = 2'd2;

    // cull reasons
    localparam logic [1:0] CULL_NONE   = 2'd0;
    localparam logic [1:0] CULL_PLANE  = 2'd1;
    localparam logic [1:0] CULL_CORNER = 2'd2;

    // defaults for the top-level parameters
    localparam int PLANE_COUNT_DEF = 6;
    localparam int COORD_BITS_DEF  = 32;

    // frustum corner table is always a full box
    localparam int CORNER_COUNT = 8;
    localparam int CORNER_IDX_W = 3;

    // fixed point one in q16.16
    localparam int ONE_SHIFT = 16;

    // sweep sequencing: one read per step, two pipeline stages behind it
    localparam int          STEP_W     = 4;
    localparam logic [3:0]  STEP_ISSUE = 4'(CORNER_COUNT);
    localparam logic [3:0]  STEP_LAST  = 4'(CORNER_COUNT + 1);

    // port field widths
    localparam int FIELD_BITS = 32;
    localparam int IN_DATA_W  = 10 * FIELD_BITS;
    localparam int IN_USER_W  = 5;
    localparam int OUT_DATA_W = 8;
    localparam int OUT_USER_W = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

endpackage

FILE: rtl/aabb_frustum_cull_test.sv
// axis-aligned box versus view frustum cull test, signed q16.16 fixed point
//
// input stream (s_axis): one transaction per item. tuser carries the kind
// (load plane, load corner, test box) and the table slot; tdata carries the
// four plane coefficients or three corner coordinates and the box min/max corners.
// loads write the plane or corner table and give no result.
// a test box gives exactly one result on the output stream (m_axis):
// visible in tdata bit 0 and the cull reason in tuser.
//
// loads can be taken back to back; a test is finished before the next item is
// accepted. the test sweeps both tables through one read port each, one
// corner per cycle for 8 steps and one plane per cycle over the first
// PLANE_COUNT of them; the plane path has a memory read stage, a product
// stage (six 32x32 products) and a sum stage.
// the result is registered at the output from the done state after the sweep.
//
// s_axis_tready is high only while no test is in progress. a finished result
// sits in the output register; a stalled receiver does not block loads or
// the next test, but a second result waits in the done state until the first is
// taken. reset clears the control state only; table contents are undefined
// until loaded.
module aabb_frustum_cull_test
    import afc_pkg::*;
#(
    parameter int PLANE_COUNT = PLANE_COUNT_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // coef_x, coef_y, coef_z, coef_w, box_min_x, box_min_y, box_min_z,
    // box_max_x, box_max_y, box_max_z (32 bits each)
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action [1:0], slot [4:2]
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // visible [0], zero fill [7:1]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // cull_reason [1:0]
    output logic [OUT_USER_W-1:0] m_axis_tuser
);

    localparam int CB     = COORD_BITS;
    localparam int PW     = 2 * CB;            // exact product width
    localparam int SW     = PW + 2;            // exact width of a four-term sum
    localparam int PIDX_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

    // ---------------------------------------------------------------
    // input field split
    // ---------------------------------------------------------------
    logic [1:0]          in_action;
    logic [2:0]          in_slot;
    logic signed [CB-1:0] in_coef [4];
    logic signed [CB-1:0] in_bmin [3];
    logic signed [CB-1:0] in_bmax [3];
    logic                in_accept;

    assign in_action = s_axis_tuser[1:0];
    assign in_slot   = s_axis_tuser[4:2];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            in_coef[i] = s_axis_tdata[i*FIELD_BITS +: CB];
        end
        for (int i = 0; i < 3; i++) begin
            in_bmin[i] = s_axis_tdata[(4+i)*FIELD_BITS +: CB];
            in_bmax[i] = s_axis_tdata[(7+i)*FIELD_BITS +: CB];
        end
    end

    assign in_accept = s_axis_tvalid && s_axis_tready;

    // ---------------------------------------------------------------
    // control
    // ---------------------------------------------------------------
    t_state             r_state, n_state;
    logic [STEP_W-1:0]  r_step;
    logic               start_test;
    logic               load_out;

    logic               r_m_valid;
    logic               r_m_visible;
    logic [1:0]         r_m_reason;

    // sweep flags
    logic               r_plane_hit;
    logic [2:0]         r_all_above;
    logic [2:0]         r_all_below;

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
        start_test    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && (in_action == ACT_TEST_BOX)) begin
                    start_test = 1'b1;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_step == STEP_LAST) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (start_test) begin
                r_step <= '0;
            end else if (r_state == ST_RUN) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    // box held for the whole sweep
    logic signed [CB-1:0] r_bmin [3];
    logic signed [CB-1:0] r_bmax [3];

    always_ff @(posedge i_clk) begin
        if (start_test) begin
            r_bmin <= in_bmin;
            r_bmax <= in_bmax;
        end
    end

    // ---------------------------------------------------------------
    // plane and corner tables, one write and one registered read each
    // ---------------------------------------------------------------
    logic [4*CB-1:0] mem_plane  [PLANE_COUNT];
    logic [3*CB-1:0] mem_corner [CORNER_COUNT];
    logic [4*CB-1:0] r_plane_q;
    logic [3*CB-1:0] r_corner_q;
    logic            r_plane_qv, r_corner_qv;
    logic            plane_rd, corner_rd;

    assign plane_rd  = (r_state == ST_RUN) && (r_step < STEP_W'(PLANE_COUNT));
    assign corner_rd = (r_state == ST_RUN) && (r_step < STEP_ISSUE);

    always_ff @(posedge i_clk) begin
        if (in_accept && (in_action == ACT_LOAD_PLANE) && (4'(in_slot) < 4'(PLANE_COUNT))) begin
            mem_plane[in_slot[PIDX_W-1:0]] <= {in_coef[3], in_coef[2], in_coef[1], in_coef[0]};
        end
        if (plane_rd) begin
            r_plane_q <= mem_plane[r_step[PIDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && (in_action == ACT_LOAD_CORNER)) begin
            mem_corner[in_slot[CORNER_IDX_W-1:0]] <= {in_coef[2], in_coef[1], in_coef[0]};
        end
        if (corner_rd) begin
            r_corner_q <= mem_corner[r_step[CORNER_IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_qv  <= 1'b0;
            r_corner_qv <= 1'b0;
        end else begin
            r_plane_qv  <= plane_rd;
            r_corner_qv <= corner_rd;
        end
    end

    // ---------------------------------------------------------------
    // plane stage 1: six exact products, one per box extent and axis
    // ---------------------------------------------------------------
    logic signed [CB-1:0] pa, pb, pc, pd;
    logic signed [PW-1:0] r_px [2];
    logic signed [PW-1:0] r_py [2];
    logic signed [PW-1:0] r_pz [2];
    logic signed [SW-1:0] r_pd;
    logic                 r_prod_v;

    assign pa = r_plane_q[0*CB +: CB];
    assign pb = r_plane_q[1*CB +: CB];
    assign pc = r_plane_q[2*CB +: CB];
    assign pd = r_plane_q[3*CB +: CB];

    always_ff @(posedge i_clk) begin
        if (r_plane_qv) begin
            r_px[0] <= pa * r_bmin[0];
            r_px[1] <= pa * r_bmax[0];
            r_py[0] <= pb * r_bmin[1];
            r_py[1] <= pb * r_bmax[1];
            r_pz[0] <= pc * r_bmin[2];
            r_pz[1] <= pc * r_bmax[2];
            r_pd    <= SW'(pd) <<< ONE_SHIFT;   // d times 1.0
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
        end else begin
            r_prod_v <= r_plane_qv;
        end
    end

    // ---------------------------------------------------------------
    // plane stage 2: eight box corner sums, culled if all negative
    // ---------------------------------------------------------------
    logic [CORNER_COUNT-1:0] corner_neg;
    logic signed [SW-1:0]    corner_sum [CORNER_COUNT];

    always_comb begin
        for (int i = 0; i < CORNER_COUNT; i++) begin
            logic [2:0] k;
            k = 3'(i);
            corner_sum[i] = SW'(r_px[k[0]]) + SW'(r_py[k[1]]) + SW'(r_pz[k[2]]) + r_pd;
            corner_neg[i] = corner_sum[i][SW-1];
        end
    end

    // ---------------------------------------------------------------
    // frustum corner against box faces
    // ---------------------------------------------------------------
    logic [2:0] above, below;

    always_comb begin
        for (int ax = 0; ax < 3; ax++) begin
            above[ax] = $signed(r_corner_q[ax*CB +: CB]) > r_bmax[ax];
            below[ax] = $signed(r_corner_q[ax*CB +: CB]) < r_bmin[ax];
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_test) begin
            r_plane_hit <= 1'b0;
            r_all_above <= '1;
            r_all_below <= '1;
        end else begin
            if (r_prod_v && (&corner_neg)) begin
                r_plane_hit <= 1'b1;
            end
            if (r_corner_qv) begin
                r_all_above <= r_all_above & above;
                r_all_below <= r_all_below & below;
            end
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    logic [1:0] reason;

    always_comb begin
        if (r_plane_hit) begin
            reason = CULL_PLANE;
        end else if ((|r_all_above) || (|r_all_below)) begin
            reason = CULL_CORNER;
        end else begin
            reason = CULL_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load_out) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_m_visible <= (reason == CULL_NONE);
            r_m_reason  <= reason;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {(OUT_DATA_W-1)'(0), r_m_visible};
    assign m_axis_tuser  = r_m_reason;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_test_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (in_action == ACT_TEST_BOX)) |=> (r_state == ST_RUN && r_step == '0))
        else $error("test accept did not start the sweep");

    a_step_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_step <= STEP_LAST))
        else $error("sweep counter ran past its end");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result loaded outside the done state");

    a_visible_matches_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> (r_m_visible == (r_m_reason == CULL_NONE)))
        else $error("visible flag disagrees with cull reason");

endmodule
